/* src/tmwf_pkg.sv */
// Shared types and constants for the trimmed-mean window filter.
// No dependencies; every other file in src imports this package.
package tmwf_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int MEAN_W         = 20;
  localparam int NUM_AXES       = 3;
  localparam int FRAC_W         = 4;
  localparam int WLEN_W         = 5;
  localparam int LEN_MIN        = 3;
  localparam int MAX_WINDOW_DEF = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd12;

  // Register index, taken from the word address bits of paddr.
  localparam logic REG_WINDOW_LEN = 1'b0;

  // Control from the sequencer to each per-axis accumulator.
  typedef struct packed {
    logic en;     // a ring entry is on the read data bus
    logic first;  // that entry is slot 0, the first read of the walk
    logic trim;   // latch sum minus minimum minus maximum
  } acc_ctrl_t;

endpackage

/* src/tmwf_ring.sv */
// Sample ring: one synchronous memory holding all three axes per entry.
// Uses tmwf_pkg; single write port and single registered read port.
module tmwf_ring
  import tmwf_pkg::*;
#(
  parameter int DEPTH = MAX_WINDOW_DEF,
  parameter int AW    = $clog2(MAX_WINDOW_DEF)
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [NUM_AXES*SAMPLE_W-1:0]   wr_data,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [NUM_AXES*SAMPLE_W-1:0]   rd_data
);

  logic [NUM_AXES*SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/tmwf_acc.sv */
// Per-axis accumulator: running sum, minimum and maximum over the ring walk.
// Uses tmwf_pkg for the sample width and the acc_ctrl_t control group.
module tmwf_acc
  import tmwf_pkg::*;
#(
  parameter int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW_DEF)
) (
  input  logic                       clk,
  input  acc_ctrl_t                  ctrl,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [SUM_W-1:0]    diff_r
);

  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] lo_r;
  logic signed [SAMPLE_W-1:0] hi_r;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      if (ctrl.first) begin
        sum_r <= SUM_W'(sample);
        lo_r  <= sample;
        hi_r  <= sample;
      end else begin
        sum_r <= sum_r + SUM_W'(sample);
        if (sample < lo_r) begin
          lo_r <= sample;
        end
        if (sample > hi_r) begin
          hi_r <= sample;
        end
      end
    end
    if (ctrl.trim) begin
      diff_r <= sum_r - SUM_W'(lo_r) - SUM_W'(hi_r);
    end
  end

endmodule

/* src/tmwf_div.sv */
// Restoring divider, one quotient bit per cycle, signed dividend, truncating.
// Uses tmwf_pkg for its default widths; one instance serves each axis.
module tmwf_div
  import tmwf_pkg::*;
#(
  parameter int NUM_W = SAMPLE_W + FRAC_W + $clog2(MAX_WINDOW_DEF),
  parameter int DEN_W = $clog2(MAX_WINDOW_DEF + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0]        divisor,
  output logic                    done,
  output logic signed [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] mag_r;
  logic [DEN_W:0]   rem_r;
  logic             neg_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic signed [NUM_W-1:0] quot_r;

  logic [DEN_W:0] rem_sh;
  logic           ge;
  logic [DEN_W:0] rem_nxt;

  // The remainder stays below the divisor, so its top bit is free for the shift.
  always_comb begin
    rem_sh  = {rem_r[DEN_W-1:0], mag_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_nxt = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == '0);
      if (start) begin
        mag_r  <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
        neg_r  <= dividend[NUM_W-1];
        rem_r  <= '0;
        cnt_r  <= CW'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          mag_r <= {mag_r[NUM_W-2:0], ge};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 1'b1;
        end else begin
          quot_r <= neg_r ? -$signed(mag_r) : $signed(mag_r);
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

/* src/trimmed_mean_window_filter_core.sv */
// Trimmed-mean window filter, top level: sequencer, ring, accumulators, dividers.
// While the window fills, a beat is taken every cycle and gives no result.
// Once full, each beat starts a walk of the L window entries (L is the effective
// window length) through the single ring read port, then the trim and the
// bit-serial dividers over NUM_W bits (24 at MAX_WINDOW 16); in_stall stays
// high until the result reaches the output register, so no new beat is taken
// before the last one is through.
// Synchronous active-low reset clears the slot pointer, the fill flag, the
// output valid and restores window_len to 12; the ring itself is not cleared.
module trimmed_mean_window_filter_core
  import tmwf_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_x,
  input  logic signed [SAMPLE_W-1:0] in_sample_y,
  input  logic signed [SAMPLE_W-1:0] in_sample_z,

  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [MEAN_W-1:0]   out_mean_x,
  output logic signed [MEAN_W-1:0]   out_mean_y,
  output logic signed [MEAN_W-1:0]   out_mean_z,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CFG_ADDR_W-1:0]      paddr,
  input  logic [CFG_DATA_W-1:0]      pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int IW    = $clog2(MAX_WINDOW);
  localparam int LW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int NUM_W = SUM_W + FRAC_W;
  localparam int RW    = NUM_AXES * SAMPLE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LAST,
    ST_TRIM,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t            state_r;
  logic [WLEN_W-1:0] window_len_r;
  logic [IW-1:0]     write_slot_r;
  logic              window_full_r;
  logic [IW-1:0]     rd_idx_r;
  logic              dat_vld_r;
  logic              dat_first_r;
  logic              go_r;
  logic              out_valid_r;
  logic signed [MEAN_W-1:0] mean_x_r;
  logic signed [MEAN_W-1:0] mean_y_r;
  logic signed [MEAN_W-1:0] mean_z_r;

  logic [LW-1:0] len_eff;
  logic [LW-1:0] slot_cur;
  logic [LW-1:0] slot_inc;
  logic          wrap;
  logic          in_acc;
  logic          cfg_wr;
  logic          rd_last;
  logic          out_free;

  logic [RW-1:0]           rd_data;
  acc_ctrl_t               acc_ctrl;
  logic signed [SUM_W-1:0] diff [NUM_AXES];
  logic signed [NUM_W-1:0] quot [NUM_AXES];
  logic [NUM_AXES-1:0]     div_done;

  // Effective length: the register clamped to LEN_MIN..MAX_WINDOW.
  always_comb begin
    if (window_len_r < WLEN_W'(LEN_MIN)) begin
      len_eff = LW'(LEN_MIN);
    end else if (32'(window_len_r) > MAX_WINDOW) begin
      len_eff = LW'(MAX_WINDOW);
    end else begin
      len_eff = LW'(window_len_r);
    end
  end

  // A slot left beyond a shortened window restarts at slot 0.
  assign slot_cur = (LW'(write_slot_r) >= len_eff) ? '0 : LW'(write_slot_r);
  assign slot_inc = slot_cur + 1'b1;
  assign wrap     = slot_inc >= len_eff;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN);
  assign rd_last   = (LW'(rd_idx_r) == (len_eff - 1'b1));
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      window_len_r  <= WLEN_RESET;
      write_slot_r  <= '0;
      window_full_r <= 1'b0;
      rd_idx_r      <= '0;
      dat_vld_r     <= 1'b0;
      dat_first_r   <= 1'b0;
      go_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      dat_vld_r   <= (state_r == ST_WALK);
      dat_first_r <= (state_r == ST_WALK) && (rd_idx_r == '0);
      go_r        <= (state_r == ST_TRIM);
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc && !cfg_wr) begin
            write_slot_r <= wrap ? '0 : IW'(slot_inc);
            if (wrap) begin
              window_full_r <= 1'b1;
            end
            if (wrap || window_full_r) begin
              rd_idx_r <= '0;
              state_r  <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          rd_idx_r <= rd_idx_r + 1'b1;
          if (rd_last) begin
            state_r <= ST_LAST;
          end
        end
        ST_LAST: begin
          state_r <= ST_TRIM;
        end
        ST_TRIM: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (&div_done) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            mean_x_r    <= quot[0][MEAN_W-1:0];
            mean_y_r    <= quot[1][MEAN_W-1:0];
            mean_z_r    <= quot[2][MEAN_W-1:0];
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // Any write to the length register restarts the fill.
      if (cfg_wr) begin
        window_len_r  <= pwdata[WLEN_W-1:0];
        write_slot_r  <= '0;
        window_full_r <= 1'b0;
      end
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW_LEN) ? CFG_DATA_W'(window_len_r) : '0;
  assign pready = 1'b1;

  tmwf_ring #(
    .DEPTH (MAX_WINDOW),
    .AW    (IW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (IW'(slot_cur)),
    .wr_data ({in_sample_z, in_sample_y, in_sample_x}),
    .rd_en   (state_r == ST_WALK),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  assign acc_ctrl.en    = dat_vld_r;
  assign acc_ctrl.first = dat_first_r;
  assign acc_ctrl.trim  = (state_r == ST_TRIM);

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    tmwf_acc #(
      .SUM_W (SUM_W)
    ) u_acc (
      .clk    (clk),
      .ctrl   (acc_ctrl),
      .sample ($signed(rd_data[a*SAMPLE_W +: SAMPLE_W])),
      .diff_r (diff[a])
    );

    tmwf_div #(
      .NUM_W (NUM_W),
      .DEN_W (LW)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (go_r),
      .dividend ($signed({diff[a], {FRAC_W{1'b0}}})),
      .divisor  (len_eff - LW'(2)),
      .done     (div_done[a]),
      .quotient (quot[a])
    );
  end

  assign out_valid  = out_valid_r;
  assign out_mean_x = mean_x_r;
  assign out_mean_y = mean_y_r;
  assign out_mean_z = mean_z_r;

endmodule
